FILE: design/assert_macros.svh
// Assertion helpers for the cache block
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked on every rising clock edge outside reset
`define ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication checked outside reset
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: design/lrukv_pkg.sv
`default_nettype none
package lrukv_pkg;
    localparam int MAX_ENTRIES_DEF = 16;
    localparam int DATA_WIDTH_DEF  = 32;
    localparam int KEY_WIDTH       = 32;
    localparam int CAP_WIDTH       = 5;
    localparam logic [CAP_WIDTH-1:0] CAP_RESET = 5'd16;

    localparam logic REQ_GET = 1'b0;
    localparam logic REQ_PUT = 1'b1;
endpackage
`default_nettype wire

FILE: design/lru_key_value_cache.sv
// The back end compares an item as it takes it from the queue and registers
// the match vector; the rank/store update stage then writes a put, or fills
// the output register for a get. No item is taken while one is in the update
// stage or a get result waits. The front queue holds two items.
// Reset: synchronous active-low i_rst_n empties the store and the queue and
// sets capacity to 16; no clearing pass.
`default_nettype none
module lru_key_value_cache #(
    parameter int MAX_ENTRIES = lrukv_pkg::MAX_ENTRIES_DEF,
    parameter int DATA_WIDTH  = lrukv_pkg::DATA_WIDTH_DEF
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_cfg_we,
    input  wire logic [lrukv_pkg::CAP_WIDTH-1:0] i_cfg_wdata,
    input  wire logic                            i_valid,
    output logic                                 o_ready,
    input  wire logic                            i_req_type,
    input  wire logic [31:0]                     i_lookup_key,
    input  wire logic [DATA_WIDTH-1:0]           i_write_value,
    output logic                                 o_valid,
    input  wire logic                            i_ready,
    output logic                                 o_hit,
    output logic [31:0]                          o_read_value
);
    logic [lrukv_pkg::CAP_WIDTH-1:0] r_cap;
    logic                            q_valid, q_pop, q_type;
    logic [31:0]                     q_key;
    logic [DATA_WIDTH-1:0]           q_wval;

    // capacity register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_cap <= lrukv_pkg::CAP_RESET;
        else if (i_cfg_we) r_cap <= i_cfg_wdata;
    end

    lrukv_front #(.DATA_WIDTH(DATA_WIDTH)) u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(i_valid), .o_ready(o_ready),
        .i_req_type(i_req_type), .i_key(i_lookup_key), .i_wval(i_write_value),
        .o_q_valid(q_valid), .i_q_pop(q_pop),
        .o_q_type(q_type), .o_q_key(q_key), .o_q_wval(q_wval)
    );

    lrukv_back #(.MAX_ENTRIES(MAX_ENTRIES), .DATA_WIDTH(DATA_WIDTH)) u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cap(r_cap),
        .i_q_valid(q_valid), .o_q_pop(q_pop),
        .i_q_type(q_type), .i_q_key(q_key), .i_q_wval(q_wval),
        .o_valid(o_valid), .i_ready(i_ready),
        .o_hit(o_hit), .o_read_value(o_read_value)
    );
endmodule
`default_nettype wire

FILE: design/lrukv_front.sv
`default_nettype none
`include "assert_macros.svh"
// Front end: accepts items into a two-entry queue
module lrukv_front #(
    parameter int DATA_WIDTH = lrukv_pkg::DATA_WIDTH_DEF
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_valid,
    output logic                              o_ready,
    input  wire logic                         i_req_type,
    input  wire logic [lrukv_pkg::KEY_WIDTH-1:0] i_key,
    input  wire logic [DATA_WIDTH-1:0]        i_wval,
    output logic                              o_q_valid,
    input  wire logic                         i_q_pop,
    output logic                              o_q_type,
    output logic [lrukv_pkg::KEY_WIDTH-1:0]   o_q_key,
    output logic [DATA_WIDTH-1:0]             o_q_wval
);
    localparam int QW = 1 + lrukv_pkg::KEY_WIDTH + DATA_WIDTH;

    logic [QW-1:0] r_mem [2];
    logic          r_wp, r_rp;
    logic [1:0]    r_cnt;
    logic          push;

    assign o_ready   = (r_cnt != 2'd2);
    assign push      = i_valid && o_ready;
    assign o_q_valid = (r_cnt != 2'd0);
    assign {o_q_type, o_q_key, o_q_wval} = r_mem[r_rp];

    // payload storage
    always_ff @(posedge i_clk) begin
        if (push) r_mem[r_wp] <= {i_req_type, i_key, i_wval};
    end

    // pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (push) r_wp <= ~r_wp;
            if (i_q_pop) r_rp <= ~r_rp;
            r_cnt <= r_cnt + {1'b0, push} - {1'b0, i_q_pop};
        end
    end

    `ASSERT_IMPL(a_no_pop_empty, i_clk, i_rst_n, i_q_pop, o_q_valid, "pop from empty queue")
    `ASSERT_IMPL(a_cnt_range, i_clk, i_rst_n, 1'b1, r_cnt != 2'd3, "queue count overflow")
endmodule
`default_nettype wire

FILE: design/lrukv_back.sv
`default_nettype none
`include "assert_macros.svh"
// Back end: compare in parallel, then update ranks and storage and register get results
module lrukv_back #(
    parameter int MAX_ENTRIES = lrukv_pkg::MAX_ENTRIES_DEF,
    parameter int DATA_WIDTH  = lrukv_pkg::DATA_WIDTH_DEF
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic [lrukv_pkg::CAP_WIDTH-1:0] i_cap,
    input  wire logic                            i_q_valid,
    output logic                                 o_q_pop,
    input  wire logic                            i_q_type,
    input  wire logic [lrukv_pkg::KEY_WIDTH-1:0] i_q_key,
    input  wire logic [DATA_WIDTH-1:0]           i_q_wval,
    output logic                                 o_valid,
    input  wire logic                            i_ready,
    output logic                                 o_hit,
    output logic [31:0]                          o_read_value
);
    localparam int IW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
    localparam int CW = $clog2(MAX_ENTRIES + 1);
    localparam int KW = lrukv_pkg::KEY_WIDTH;

    logic [KW-1:0]         r_keys [MAX_ENTRIES];
    logic [DATA_WIDTH-1:0] r_vals [MAX_ENTRIES];
    logic [MAX_ENTRIES-1:0] r_vld;
    logic [IW-1:0]         r_rank [MAX_ENTRIES];
    logic [CW-1:0]         r_count;

    // stage 1 registers: item and match vector
    logic                   r_s1;
    logic                   r_type;
    logic [KW-1:0]          r_key;
    logic [DATA_WIDTH-1:0]  r_wval;
    logic [MAX_ENTRIES-1:0] r_match;

    logic                   r_ovalid;
    logic                   r_ohit;
    logic [31:0]            r_oval;

    logic [MAX_ENTRIES-1:0] match;
    logic                   take;
    always_comb begin
        for (int i = 0; i < MAX_ENTRIES; i++)
            match[i] = r_vld[i] && (r_keys[i] == i_q_key);
    end
    assign take    = i_q_valid && !r_s1 && !r_ovalid;
    assign o_q_pop = take;

    // stage 2: slot choice
    logic          hit;
    logic [IW-1:0] hslot, fslot, lslot, slot;
    logic          found_free;
    logic [CW-1:0] ecap;
    logic          full;
    logic          insert;
    logic [IW-1:0] prank;
    always_comb begin
        hit = |r_match;
        hslot = '0;
        fslot = '0;
        lslot = '0;
        found_free = 1'b0;
        for (int i = MAX_ENTRIES - 1; i >= 0; i--) begin
            if (r_match[i]) hslot = IW'(i);
            if (!r_vld[i]) begin fslot = IW'(i); found_free = 1'b1; end
        end
        // least recent: rank equals count-1
        for (int i = MAX_ENTRIES - 1; i >= 0; i--)
            if (r_vld[i] && (CW'(r_rank[i]) == r_count - CW'(1))) lslot = IW'(i);
        if (i_cap == '0) ecap = CW'(1);
        else if (32'(i_cap) > MAX_ENTRIES) ecap = CW'(MAX_ENTRIES);
        else ecap = CW'(i_cap);
        full   = (r_count >= ecap) || !found_free;
        insert = (r_type == lrukv_pkg::REQ_PUT) && !hit && !full;
        if (hit) slot = hslot;
        else if (full) slot = lslot;
        else slot = fslot;
        if (insert) prank = IW'(r_count);
        else prank = r_rank[slot];
    end

    logic update;
    assign update = r_s1 && ((r_type == lrukv_pkg::REQ_PUT) || hit);

    // storage and rank update
    always_ff @(posedge i_clk) begin
        if (r_s1 && r_type == lrukv_pkg::REQ_PUT) begin
            r_vals[slot] <= r_wval;
            if (!hit) r_keys[slot] <= r_key;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld   <= '0;
            r_count <= '0;
            for (int i = 0; i < MAX_ENTRIES; i++) r_rank[i] <= '0;
        end else if (update) begin
            for (int i = 0; i < MAX_ENTRIES; i++)
                if (r_vld[i] && r_rank[i] < prank && IW'(i) != slot)
                    r_rank[i] <= r_rank[i] + 1'b1;
            r_rank[slot] <= '0;
            if (insert) begin
                r_vld[slot] <= 1'b1;
                r_count     <= r_count + 1'b1;
            end
        end
    end

    // stage 1 capture
    always_ff @(posedge i_clk) begin
        if (take) begin
            r_type  <= i_q_type;
            r_key   <= i_q_key;
            r_wval  <= i_q_wval;
            r_match <= match;
        end
    end

    // control and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1     <= 1'b0;
            r_ovalid <= 1'b0;
        end else begin
            r_s1 <= take;
            if (r_s1 && r_type == lrukv_pkg::REQ_GET) r_ovalid <= 1'b1;
            else if (i_ready) r_ovalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_s1 && r_type == lrukv_pkg::REQ_GET) begin
            r_ohit <= hit;
            r_oval <= hit ? 32'(r_vals[slot]) : 32'd0;
        end
    end

    assign o_valid      = r_ovalid;
    assign o_hit        = r_ohit;
    assign o_read_value = r_oval;

    `ASSERT_IMPL(a_onehot_match, i_clk, i_rst_n, r_s1, $onehot0(r_match), "duplicate key")
    `ASSERT_IMPL(a_count_le, i_clk, i_rst_n, 1'b1, 32'(r_count) <= MAX_ENTRIES, "count overflow")
    `ASSERT_NEXT(a_insert_cnt, i_clk, i_rst_n, update && insert, r_count == $past(r_count) + 1'b1,
        "insert did not count")
endmodule
`default_nettype wire
